// ===== rtl/srd_pkg.sv =====
package srd_pkg;

  localparam int unsigned MagMax = 32767;
  localparam int unsigned DzRst  = 7849;
  localparam int unsigned QBits  = 16;   // quotient bits found per lane, one per stage
  localparam int unsigned NStg   = QBits;

  localparam logic [31:0] CLIP_SQ = 32'(MagMax * MagMax);
  localparam logic [15:0] DIR_MAX = 16'(MagMax);
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef enum logic [1:0] {
    NORM_DEAD,
    NORM_CLIP,
    NORM_CALC
  } norm_e;

  // values derived from the dead zone at write time
  typedef struct packed {
    logic [29:0] dz2;      // dz^2
    logic [29:0] den2;     // (32767 - dz)^2
    logic [29:0] dendz;    // (32767 - dz) * dz
    logic        den_zero;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    dz2:      30'(DzRst * DzRst),
    den2:     30'((MagMax - DzRst) * (MagMax - DzRst)),
    dendz:    30'(DzRst * (MagMax - DzRst)),
    den_zero: 1'b0
  };

  // classified item between front and back
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        zero;
    norm_e       kind;
    logic [30:0] xsq;
    logic [30:0] ysq;
    logic [31:0] s;
  } item_t;

  // one search lane: residual, cross term, quotient bits so far
  typedef struct packed {
    logic [63:0] r;
    logic [63:0] c;
    logic [15:0] q;
  } lane_t;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        zero;
    norm_e       kind;
    logic [63:0] us;
    lane_t [2:0] ln;
  } stage_t;

  // try bit k: (t + 2^k*d)^2 - t^2 = 2^(k+1)*c + 2^(2k)*u with c = d*t, u = d^2
  function automatic lane_t lane_step(lane_t l, logic [63:0] u, int k);
    lane_t       o;
    logic [63:0] cand;
    o    = l;
    cand = (l.c << (k + 1)) + (u << (2 * k));
    if (l.r >= cand) begin
      o.r    = l.r - cand;
      o.c    = l.c + (u << k);
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

endpackage

// ===== rtl/srd_front.sv =====
module srd_front import srd_pkg::*; (
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  cfg_t               cfg_i,
  output item_t              item_o
);

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic        [31:0] s;

  assign px = stick_x_i * stick_x_i;
  assign py = stick_y_i * stick_y_i;
  assign s  = {1'b0, px[30:0]} + {1'b0, py[30:0]};

  always_comb begin
    item_o.neg_x = stick_x_i[15];
    item_o.neg_y = stick_y_i[15];
    item_o.zero  = (s == '0);
    item_o.xsq   = px[30:0];
    item_o.ysq   = py[30:0];
    item_o.s     = s;
    if (s <= {2'b00, cfg_i.dz2} || cfg_i.den_zero) begin
      item_o.kind = NORM_DEAD;
    end else if (s >= CLIP_SQ) begin
      item_o.kind = NORM_CLIP;
    end else begin
      item_o.kind = NORM_CALC;
    end
  end

endmodule

// ===== rtl/srd_fifo.sv =====
module srd_fifo import srd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  vld_o,
  output item_t head_o
);

  item_t       ent_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = (cnt_q != 2'd0);
  assign head_o = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/srd_back.sv =====
module srd_back import srd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_vld_i,
  input  item_t              head_i,
  output logic               pop_o,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic        [15:0] norm_magnitude_o
);

  logic        en;
  logic        vld_q [NStg+1];
  stage_t      st_q  [NStg+1];
  stage_t      st_d  [NStg+1];
  stage_t      init;
  logic [63:0] un;
  logic        out_vld_q;
  logic [15:0] dx_q, dx_d, dy_q, dy_d, nm_q, nm_d;

  assign en    = !(out_vld_q && out_stall_i);
  assign pop_o = head_vld_i && en;
  assign un    = {34'd0, cfg_i.den2};

  always_comb begin
    init.neg_x = head_i.neg_x;
    init.neg_y = head_i.neg_y;
    init.zero  = head_i.zero;
    init.kind  = head_i.kind;
    init.us    = {32'd0, head_i.s};
    init.ln[0] = '{r: {33'd0, head_i.xsq} << 30, c: '0, q: '0};
    init.ln[1] = '{r: {33'd0, head_i.ysq} << 30, c: '0, q: '0};
    // only meaningful for NORM_CALC, where s > dz^2
    init.ln[2] = '{r: ({32'd0, head_i.s} - {34'd0, cfg_i.dz2}) << 30,
                   c: {34'd0, cfg_i.dendz} << 15, q: '0};
  end

  assign st_d[0] = init;

  for (genvar i = 0; i < NStg; i++) begin : g_stg
    always_comb begin
      st_d[i+1]       = st_q[i];
      st_d[i+1].ln[0] = lane_step(st_q[i].ln[0], st_q[i].us, NStg - 1 - i);
      st_d[i+1].ln[1] = lane_step(st_q[i].ln[1], st_q[i].us, NStg - 1 - i);
      st_d[i+1].ln[2] = lane_step(st_q[i].ln[2], un, NStg - 1 - i);
    end
  end

  for (genvar i = 0; i <= NStg; i++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= (i == 0) ? head_vld_i : vld_q[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // saturate / negate the direction quotients
  always_comb begin
    stage_t f;
    f = st_q[NStg];
    if (f.zero) begin
      dx_d = '0;
    end else if (f.neg_x) begin
      dx_d = 16'(17'h10000 - {1'b0, f.ln[0].q});
    end else begin
      dx_d = (f.ln[0].q > DIR_MAX) ? DIR_MAX : f.ln[0].q;
    end
    if (f.zero) begin
      dy_d = '0;
    end else if (f.neg_y) begin
      dy_d = 16'(17'h10000 - {1'b0, f.ln[1].q});
    end else begin
      dy_d = (f.ln[1].q > DIR_MAX) ? DIR_MAX : f.ln[1].q;
    end
    unique case (f.kind)
      NORM_CLIP: nm_d = ONE_Q15;
      NORM_CALC: nm_d = f.ln[2].q;
      default:   nm_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      nm_q <= nm_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign dir_x_o          = dx_q;
  assign dir_y_o          = dy_q;
  assign norm_magnitude_o = nm_q;

endmodule

// ===== rtl/stick_radial_deadzone_top.sv =====
// channel | handshake                     | payload
// in      | in_valid_i / in_stall_o       | stick_x_i, stick_y_i (s16)
// out     | out_valid_o / out_stall_i     | dir_x_o, dir_y_o (s16 Q1.15), norm_magnitude_o (u16)
// cfg     | cfg_we_i                      | cfg_wdata_i (dead zone, u15)
//
// One item per cycle sustained unless the output stalls. Path through an empty block:
// front squares into a 2-entry queue, 17 stage registers of the bit-per-stage
// search (16 quotient bits per lane), then the output register.
// Reset clears valids, queue pointers and loads a dead zone of 7849.
// A stalled output freezes the back pipeline; the queue keeps taking items
// until full, then in_stall_o rises.
module stick_radial_deadzone_top import srd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic        [15:0] norm_magnitude_o,
  input  logic               cfg_we_i,
  input  logic        [14:0] cfg_wdata_i
);

  cfg_t        cfg_q, cfg_d;
  logic [14:0] den;
  item_t       item;
  item_t       head;
  logic        full;
  logic        head_vld;
  logic        pop;
  logic        push;

  // derived dead zone terms, products formed once at write time
  always_comb begin
    den            = 15'(MagMax) - cfg_wdata_i;
    cfg_d.dz2      = 30'(cfg_wdata_i * cfg_wdata_i);
    cfg_d.den2     = 30'(den * den);
    cfg_d.dendz    = 30'(den * cfg_wdata_i);
    cfg_d.den_zero = (den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign push       = in_valid_i && !full;
  assign in_stall_o = full;

  srd_front u_front (
    .stick_x_i (stick_x_i),
    .stick_y_i (stick_y_i),
    .cfg_i     (cfg_q),
    .item_o    (item)
  );

  srd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (pop),
    .full_o (full),
    .vld_o  (head_vld),
    .head_o (head)
  );

  srd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_vld_i       (head_vld),
    .head_i           (head),
    .pop_o            (pop),
    .cfg_i            (cfg_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dir_x_o          (dir_x_o),
    .dir_y_o          (dir_y_o),
    .norm_magnitude_o (norm_magnitude_o)
  );

endmodule
